[hw/rtl/huffman_code_table_builder_assert.svh]
// Assertion macros used by the Huffman code table builder datapath
`ifndef HUFFMAN_CODE_TABLE_BUILDER_ASSERT_SVH
`define HUFFMAN_CODE_TABLE_BUILDER_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define HCTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define HCTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/hctb_pkg.sv]
// Types and constants of the Huffman code table builder
`timescale 1ns / 1ps
package hctb_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int MAX_CODE_LEN  = 32;
  localparam int COUNT_WIDTH   = 24;

  localparam int IDX_W   = $clog2(ALPHABET_SIZE);
  localparam int NODE_W  = IDX_W + 1;
  localparam int SLOTS   = 2 * ALPHABET_SIZE;
  localparam int WGT_W   = 32;
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int TOT_W   = 40;
  localparam int DIST_W  = 9;
  localparam int PROD_W  = COUNT_WIDTH + LEN_W;
  localparam int LEN_LIMIT = (MAX_CODE_LEN > 63) ? 63 : MAX_CODE_LEN;

  localparam logic [NODE_W-1:0] NIL = '1;

  typedef enum logic [1:0] {
    CMD_COUNT  = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CNT_WR,
    OP_LK_OUT,
    OP_B_INIT,
    OP_S_RD,
    OP_S_CHK,
    OP_S_NEXT,
    OP_INS_RD,
    OP_INS_CMP,
    OP_INS_LINK,
    OP_INS_LINK2,
    OP_M_START,
    OP_M_ONE,
    OP_M_ZERO,
    OP_M_NEXT,
    OP_C_INIT,
    OP_C_RD,
    OP_C_ONE,
    OP_C_ZERO,
    OP_F_INIT,
    OP_F_RD,
    OP_F_ACC,
    OP_B_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } ctl_t;

  typedef struct packed {
    logic cnt_nz;
    logic i_last;
    logic p_nil;
    logic p_less;
    logic a_nil;
    logic head_nil;
    logic zero_nil;
    logic root_leaf;
    logic code_last;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/hctb_ctrl.sv]
// Sequencer of the Huffman code table builder
`timescale 1ns / 1ps
module hctb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    cmd_i,
  input  hctb_pkg::sts_t sts_i,
  output hctb_pkg::ctl_t ctl_o
);
  import hctb_pkg::*;

  typedef enum logic [22:0] {
    ST_IDLE      = 23'h000001,
    ST_CNT_WR    = 23'h000002,
    ST_LK_OUT    = 23'h000004,
    ST_B_INIT    = 23'h000008,
    ST_S_RD      = 23'h000010,
    ST_S_CHK     = 23'h000020,
    ST_S_NEXT    = 23'h000040,
    ST_INS_RD    = 23'h000080,
    ST_INS_CMP   = 23'h000100,
    ST_INS_LINK  = 23'h000200,
    ST_INS_LINK2 = 23'h000400,
    ST_M_START   = 23'h000800,
    ST_M_ONE     = 23'h001000,
    ST_M_ZERO    = 23'h002000,
    ST_M_NEXT    = 23'h004000,
    ST_C_INIT    = 23'h008000,
    ST_C_RD      = 23'h010000,
    ST_C_ONE     = 23'h020000,
    ST_C_ZERO    = 23'h040000,
    ST_F_INIT    = 23'h080000,
    ST_F_RD      = 23'h100000,
    ST_F_ACC     = 23'h200000,
    ST_B_OUT     = 23'h400000
  } state_e;

  state_e state_q, state_d;
  logic   ret_q, ret_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    ctl_o.op  = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.op = OP_ACCEPT;
          case (cmd_e'(cmd_i))
            CMD_COUNT:  state_d = ST_CNT_WR;
            CMD_BUILD:  state_d = ST_B_INIT;
            CMD_LOOKUP: state_d = ST_LK_OUT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_CNT_WR: begin
        ctl_o.op = OP_CNT_WR;
        state_d  = ST_IDLE;
      end
      ST_LK_OUT: begin
        ctl_o.op = OP_LK_OUT;
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_B_INIT: begin
        ctl_o.op = OP_B_INIT;
        state_d  = ST_S_RD;
      end
      ST_S_RD: begin
        ctl_o.op = OP_S_RD;
        state_d  = ST_S_CHK;
      end
      ST_S_CHK: begin
        ctl_o.op = OP_S_CHK;
        if (sts_i.cnt_nz) begin
          ret_d   = 1'b0;
          state_d = ST_INS_RD;
        end else begin
          state_d = ST_S_NEXT;
        end
      end
      ST_S_NEXT: begin
        ctl_o.op = OP_S_NEXT;
        state_d  = sts_i.i_last ? ST_M_START : ST_S_RD;
      end
      ST_INS_RD: begin
        ctl_o.op = OP_INS_RD;
        state_d  = sts_i.p_nil ? ST_INS_LINK : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        ctl_o.op = OP_INS_CMP;
        state_d  = sts_i.p_less ? ST_INS_RD : ST_INS_LINK;
      end
      ST_INS_LINK: begin
        ctl_o.op = OP_INS_LINK;
        if (!sts_i.a_nil) state_d = ST_INS_LINK2;
        else              state_d = ret_q ? ST_M_NEXT : ST_S_NEXT;
      end
      ST_INS_LINK2: begin
        ctl_o.op = OP_INS_LINK2;
        state_d  = ret_q ? ST_M_NEXT : ST_S_NEXT;
      end
      ST_M_START: begin
        ctl_o.op = OP_M_START;
        state_d  = sts_i.head_nil ? ST_B_OUT : ST_M_ONE;
      end
      ST_M_ONE: begin
        ctl_o.op = OP_M_ONE;
        state_d  = sts_i.zero_nil ? ST_C_INIT : ST_M_ZERO;
      end
      ST_M_ZERO: begin
        ctl_o.op = OP_M_ZERO;
        ret_d    = 1'b1;
        state_d  = ST_INS_RD;
      end
      ST_M_NEXT: begin
        ctl_o.op = OP_M_NEXT;
        state_d  = ST_M_START;
      end
      ST_C_INIT: begin
        ctl_o.op = OP_C_INIT;
        state_d  = sts_i.root_leaf ? ST_F_INIT : ST_C_RD;
      end
      ST_C_RD: begin
        ctl_o.op = OP_C_RD;
        state_d  = ST_C_ONE;
      end
      ST_C_ONE: begin
        ctl_o.op = OP_C_ONE;
        state_d  = ST_C_ZERO;
      end
      ST_C_ZERO: begin
        ctl_o.op = OP_C_ZERO;
        state_d  = sts_i.code_last ? ST_F_INIT : ST_C_RD;
      end
      ST_F_INIT: begin
        ctl_o.op = OP_F_INIT;
        state_d  = ST_F_RD;
      end
      ST_F_RD: begin
        ctl_o.op = OP_F_RD;
        state_d  = ST_F_ACC;
      end
      ST_F_ACC: begin
        ctl_o.op = OP_F_ACC;
        state_d  = sts_i.i_last ? ST_B_OUT : ST_F_RD;
      end
      ST_B_OUT: begin
        ctl_o.op = OP_B_OUT;
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

[hw/rtl/hctb_dp.sv]
// Datapath and stores of the Huffman code table builder
`timescale 1ns / 1ps
`include "huffman_code_table_builder_assert.svh"
module hctb_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             cmd_i,
  input  logic signed [7:0]      symbol_i,
  input  hctb_pkg::ctl_t         ctl_i,
  output hctb_pkg::sts_t         sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   kind_o,
  output logic                   found_o,
  output logic [31:0]            code_value_o,
  output logic [5:0]             code_length_o,
  output logic [8:0]             distinct_count_o,
  output logic [39:0]            total_bits_o,
  output logic                   overflow_o
);
  import hctb_pkg::*;

  logic [COUNT_WIDTH-1:0] cnt_mem [ALPHABET_SIZE];
  logic [WGT_W-1:0]       wt_mem  [SLOTS];
  logic [NODE_W-1:0]      lk_mem  [SLOTS];
  logic [2*NODE_W-1:0]    ch_mem  [SLOTS];
  logic [CODE_W-1:0]      nc_mem  [SLOTS];
  logic [LEN_W-1:0]       nl_mem  [SLOTS];
  logic [CODE_W-1:0]      tb_mem  [ALPHABET_SIZE];
  logic [LEN_W-1:0]       tl_mem  [ALPHABET_SIZE];

  logic [ALPHABET_SIZE-1:0] cnt_vld_q, in_tab_q;
  logic [COUNT_WIDTH-1:0] cnt_rd_q;
  logic                   cnt_hit_q;
  logic [WGT_W-1:0]       wt_rd_q;
  logic [NODE_W-1:0]      lk_rd_q;
  logic [2*NODE_W-1:0]    ch_rd_q;
  logic [CODE_W-1:0]      nc_rd_q, tb_rd_q;
  logic [LEN_W-1:0]       nl_rd_q, tl_rd_q;

  logic [IDX_W-1:0]  idx_q;
  logic [NODE_W-1:0] i_q, head_q, p_q, a_q, e_q, next_q, one_q, zero_q;
  logic [WGT_W-1:0]  we_q, w1_q;
  logic [DIST_W-1:0] distinct_q;
  logic [TOT_W-1:0]  total_q;
  logic              ovf_q, sat_q, found_q, out_valid_q;

  logic [IDX_W-1:0]       idx_in;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic                   out_free, out_load;

  logic                   cnt_re, cnt_we;
  logic [IDX_W-1:0]       cnt_ra, cnt_wa;
  logic [COUNT_WIDTH-1:0] cnt_wd;
  logic                   wl_re, wt_we, lk_we, ch_we, nc_re, nc_we, tb_we;
  logic [NODE_W-1:0]      wl_ra, wt_wa, lk_wa, lk_wd, nc_ra, nc_wa;
  logic [WGT_W-1:0]       wt_wd;
  logic [CODE_W-1:0]      nc_wd;
  logic [LEN_W-1:0]       nl_wd;

  logic [WGT_W:0]    wsum;
  logic [WGT_W-1:0]  wsat;
  logic [NODE_W-1:0] kid;
  logic              kid_bit, len_ok;
  logic [PROD_W-1:0] prod;
  logic [TOT_W:0]    tsum;

  assign idx_in   = {~symbol_i[7], symbol_i[6:0]};
  assign cnt_cur  = cnt_hit_q ? cnt_rd_q : '0;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = ((ctl_i.op == OP_LK_OUT) || (ctl_i.op == OP_B_OUT)) && out_free;

  assign wsum    = {1'b0, w1_q} + {1'b0, wt_rd_q};
  assign wsat    = wsum[WGT_W] ? '1 : wsum[WGT_W-1:0];
  assign kid     = (ctl_i.op == OP_C_ONE) ? ch_rd_q[2*NODE_W-1:NODE_W] : ch_rd_q[NODE_W-1:0];
  assign kid_bit = (ctl_i.op == OP_C_ONE);
  assign len_ok  = nl_rd_q < LEN_W'(LEN_LIMIT);
  assign prod    = PROD_W'(cnt_cur) * PROD_W'(nl_rd_q);
  assign tsum    = {1'b0, total_q} + (TOT_W + 1)'(prod);

  always_comb begin
    sts_o.cnt_nz    = cnt_cur != '0;
    sts_o.i_last    = i_q == NODE_W'(ALPHABET_SIZE - 1);
    sts_o.p_nil     = p_q == NIL;
    sts_o.p_less    = wt_rd_q < we_q;
    sts_o.a_nil     = a_q == NIL;
    sts_o.head_nil  = head_q == NIL;
    sts_o.zero_nil  = lk_rd_q == NIL;
    sts_o.root_leaf = head_q < NODE_W'(ALPHABET_SIZE);
    sts_o.code_last = i_q == NODE_W'(ALPHABET_SIZE);
    sts_o.out_free  = out_free;
  end

  always_comb begin
    cnt_re = 1'b0; cnt_ra = i_q[IDX_W-1:0];
    cnt_we = 1'b0; cnt_wa = idx_q; cnt_wd = '0;
    wl_re = 1'b0; wl_ra = p_q;
    wt_we = 1'b0; wt_wa = i_q; wt_wd = WGT_W'(cnt_cur);
    lk_we = 1'b0; lk_wa = e_q; lk_wd = p_q;
    ch_we = 1'b0;
    nc_re = 1'b0; nc_ra = i_q;
    nc_we = 1'b0; nc_wa = kid; nc_wd = '0; nl_wd = '0;
    tb_we = 1'b0;
    case (ctl_i.op)
      OP_ACCEPT: begin
        cnt_re = 1'b1;
        cnt_ra = idx_in;
      end
      OP_CNT_WR: begin
        cnt_we = 1'b1;
        cnt_wd = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
      end
      OP_S_RD: cnt_re = 1'b1;
      OP_S_CHK: wt_we = sts_o.cnt_nz;
      OP_INS_RD: wl_re = !sts_o.p_nil;
      OP_INS_LINK: lk_we = 1'b1;
      OP_INS_LINK2: begin
        lk_we = 1'b1;
        lk_wa = a_q;
        lk_wd = e_q;
      end
      OP_M_START: begin
        wl_re = !sts_o.head_nil;
        wl_ra = head_q;
      end
      OP_M_ONE: begin
        wl_re = !sts_o.zero_nil;
        wl_ra = lk_rd_q;
      end
      OP_M_ZERO: begin
        wt_we = 1'b1;
        wt_wa = next_q;
        wt_wd = wsat;
        ch_we = 1'b1;
      end
      OP_C_INIT: begin
        nc_we = 1'b1;
        nc_wa = head_q;
      end
      OP_C_RD: nc_re = 1'b1;
      OP_C_ONE, OP_C_ZERO: begin
        nc_we = 1'b1;
        nc_wd = len_ok ? {nc_rd_q[CODE_W-2:0], kid_bit} : nc_rd_q;
        nl_wd = len_ok ? nl_rd_q + 1'b1 : nl_rd_q;
      end
      OP_F_RD: begin
        cnt_re = 1'b1;
        nc_re  = 1'b1;
        nc_ra  = {1'b0, i_q[IDX_W-1:0]};
      end
      OP_F_ACC: tb_we = sts_o.cnt_nz;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cnt_re) begin
      cnt_rd_q  <= cnt_mem[cnt_ra];
      cnt_hit_q <= cnt_vld_q[cnt_ra];
    end
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
  end

  always_ff @(posedge clk_i) begin
    if (wl_re) begin
      wt_rd_q <= wt_mem[wl_ra];
      lk_rd_q <= lk_mem[wl_ra];
    end
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    if (lk_we) lk_mem[lk_wa] <= lk_wd;
  end

  always_ff @(posedge clk_i) begin
    if (nc_re) begin
      ch_rd_q <= ch_mem[nc_ra];
      nc_rd_q <= nc_mem[nc_ra];
      nl_rd_q <= nl_mem[nc_ra];
    end
    if (ch_we) ch_mem[next_q] <= {one_q, zero_q};
    if (nc_we) begin
      nc_mem[nc_wa] <= nc_wd;
      nl_mem[nc_wa] <= nl_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_ACCEPT) begin
      tb_rd_q <= tb_mem[idx_in];
      tl_rd_q <= tl_mem[idx_in];
    end
    if (tb_we) begin
      tb_mem[i_q[IDX_W-1:0]] <= nc_rd_q;
      tl_mem[i_q[IDX_W-1:0]] <= nl_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_ACCEPT: begin
        idx_q   <= idx_in;
        found_q <= in_tab_q[idx_in];
      end
      OP_S_CHK: begin
        e_q  <= i_q;
        we_q <= WGT_W'(cnt_cur);
        p_q  <= head_q;
        a_q  <= NIL;
      end
      OP_INS_CMP: begin
        if (sts_o.p_less) begin
          a_q <= p_q;
          p_q <= lk_rd_q;
        end
      end
      OP_M_ONE: begin
        one_q  <= head_q;
        w1_q   <= wt_rd_q;
        zero_q <= lk_rd_q;
      end
      OP_M_ZERO: begin
        we_q <= wsat;
        e_q  <= next_q;
        p_q  <= lk_rd_q;
        a_q  <= NIL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q   <= '0;
      in_tab_q    <= '0;
      sat_q       <= 1'b0;
      ovf_q       <= 1'b0;
      head_q      <= NIL;
      i_q         <= '0;
      next_q      <= NODE_W'(ALPHABET_SIZE);
      distinct_q  <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (ctl_i.op)
        OP_ACCEPT: begin
          if (cmd_e'(cmd_i) == CMD_CLEAR) begin
            cnt_vld_q <= '0;
            in_tab_q  <= '0;
            sat_q     <= 1'b0;
          end
        end
        OP_CNT_WR: begin
          cnt_vld_q[idx_q] <= 1'b1;
          if (cnt_cur == '1) sat_q <= 1'b1;
        end
        OP_B_INIT: begin
          in_tab_q   <= '0;
          head_q     <= NIL;
          distinct_q <= '0;
          i_q        <= '0;
          ovf_q      <= sat_q;
          next_q     <= NODE_W'(ALPHABET_SIZE);
          total_q    <= '0;
        end
        OP_S_CHK: if (sts_o.cnt_nz) distinct_q <= distinct_q + 1'b1;
        OP_S_NEXT, OP_F_ACC: i_q <= i_q + 1'b1;
        OP_INS_LINK: if (sts_o.a_nil) head_q <= e_q;
        OP_M_ZERO: begin
          head_q <= lk_rd_q;
          if (wsum[WGT_W]) ovf_q <= 1'b1;
        end
        OP_M_NEXT: next_q <= next_q + 1'b1;
        OP_C_INIT: i_q <= head_q;
        OP_C_ONE: if (!len_ok) ovf_q <= 1'b1;
        OP_C_ZERO: begin
          i_q <= i_q - 1'b1;
          if (!len_ok) ovf_q <= 1'b1;
        end
        OP_F_INIT: i_q <= '0;
        default: ;
      endcase
      if ((ctl_i.op == OP_F_ACC) && sts_o.cnt_nz) begin
        in_tab_q[i_q[IDX_W-1:0]] <= 1'b1;
        if (tsum[TOT_W]) begin
          total_q <= '1;
          ovf_q   <= 1'b1;
        end else begin
          total_q <= tsum[TOT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (ctl_i.op == OP_LK_OUT) begin
        kind_o           <= 1'b1;
        found_o          <= found_q;
        code_value_o     <= found_q ? tb_rd_q : '0;
        code_length_o    <= found_q ? tl_rd_q : '0;
        distinct_count_o <= '0;
        total_bits_o     <= '0;
        overflow_o       <= 1'b0;
      end else begin
        kind_o           <= 1'b0;
        found_o          <= 1'b0;
        code_value_o     <= '0;
        code_length_o    <= '0;
        distinct_count_o <= distinct_q;
        total_bits_o     <= total_q;
        overflow_o       <= ovf_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  `HCTB_ASSERT(a_next_in_range, (ctl_i.op == OP_M_ZERO) |-> (next_q != NIL), "merge node index reached the list terminator")
  `HCTB_ASSERT(a_load_when_free, out_load |-> (!out_valid_q || out_ready_i), "result overwritten")
  `HCTB_ASSERT_NEXT(a_cnt_marked, ctl_i.op == OP_CNT_WR, cnt_vld_q[$past(idx_q)], "count not marked")

endmodule

[hw/rtl/huffman_code_table_builder.sv]
// Top level of the Huffman code table builder
//
// Input channel (in_valid_i/in_ready_o) carries cmd_i and symbol_i; output
// channel (out_valid_o/out_ready_i) carries one result transaction for each
// build or lookup. Count and clear produce no result.
// Count: a read-modify-write of the count memory.
// Clear: all counts and the table are dropped at once.
// Lookup: acceptance reads the table; the result is loaded once the output register is free.
// Build: the sequencer scans all 256 counts, inserts each nonzero one into a
// weight-sorted list, merges the two lightest nodes until one root is left,
// walks the tree to give each node its code, then writes the table and sums
// the total bits; each sorted insert steps over list entries one at a time.
// A new transaction is taken only once the sequencer is back in idle; a
// finished result sits in the output register meanwhile, so the next item
// may be accepted while the result still waits.
// A stalled receiver holds the result; the sequencer then waits before
// loading the next result.
// Reset empties all counts, the table and the output register at once; no
// sweep of the memories is needed.
`timescale 1ns / 1ps
module huffman_code_table_builder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic signed [7:0] symbol_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              kind_o,
  output logic              found_o,
  output logic [31:0]       code_value_o,
  output logic [5:0]        code_length_o,
  output logic [8:0]        distinct_count_o,
  output logic [39:0]       total_bits_o,
  output logic              overflow_o
);
  import hctb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  hctb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  hctb_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_i),
    .symbol_i         (symbol_i),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .found_o          (found_o),
    .code_value_o     (code_value_o),
    .code_length_o    (code_length_o),
    .distinct_count_o (distinct_count_o),
    .total_bits_o     (total_bits_o),
    .overflow_o       (overflow_o)
  );

endmodule
